### hdl/nprf_pkg.sv
// ----------------------------------------------------------------------------
// nprf_pkg
// shared constants, types and saturating fixed-point helpers of the root finder
// ----------------------------------------------------------------------------
package nprf_pkg;

  // sizing
  localparam int MAX_DEGREE = 16;
  localparam int MAX_ITER   = 64;
  localparam int FRAC_BITS  = 32;
  localparam int DATA_W     = 64;
  localparam int HALF_W     = DATA_W / 2;
  localparam int THR_W      = DATA_W - 1;
  localparam int DIX_W      = $clog2(MAX_DEGREE + 1);
  localparam int CNT_W      = $clog2(MAX_DEGREE + 2);
  localparam int RIX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int ITER_W     = $clog2(MAX_ITER + 1);
  localparam int DIV_STEPS  = 2 * DATA_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int MUL_STEPS  = 4;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);

  // fixed-point constants
  localparam logic signed [DATA_W-1:0] SMAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SMIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0]        ONE_Q = DATA_W'(1) << FRAC_BITS;

  // register reset values
  localparam logic [THR_W-1:0]         THR_RESET   = THR_W'(4295);
  localparam logic signed [DATA_W-1:0] GUESS_RESET = ONE_Q;

  // configuration register indexes
  typedef enum logic {
    CFG_CONV_THRESHOLD = 1'b0,
    CFG_INITIAL_GUESS  = 1'b1
  } cfg_idx_e;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_ROOT_START,
    OP_HSTART,
    OP_MUL_DP,
    OP_DP_ACC,
    OP_MUL_P,
    OP_P_ACC,
    OP_DIV_START,
    OP_NEWTON,
    OP_DIFF,
    OP_CHK,
    OP_DSTART,
    OP_MUL_Q,
    OP_DEFL,
    OP_NEXT_ROOT,
    OP_SORT_INIT,
    OP_SORT_LOAD,
    OP_SORT_SHIFT,
    OP_SORT_PLACE,
    OP_EMIT_INIT,
    OP_EMIT,
    OP_ABORT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic nonconst;
    logic k_zero;
    logic mul_done;
    logic div_done;
    logic dp_zero;
    logic grow;
    logic conv;
    logic cap;
    logic all_done;
    logic sort_done;
    logic sort_move;
    logic emit_last;
  } dp_status_t;

  // magnitude of a signed value
  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] a);
    return a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  endfunction

  // signed value of a magnitude, saturated
  function automatic logic signed [DATA_W-1:0] from_mag(input logic [DATA_W-1:0] m,
                                                        input logic neg,
                                                        input logic ovf);
    if (neg) begin
      if (ovf || m[DATA_W-1]) return SMIN;
      return DATA_W'(0) - $signed(m);
    end
    if (ovf || m[DATA_W-1]) return SMAX;
    return $signed(m);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? SMIN : SMAX;
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? SMIN : SMAX;
    return s[DATA_W-1:0];
  endfunction

  // |a - b| clipped to the largest positive value
  function automatic logic [DATA_W-1:0] step_size(input logic signed [DATA_W-1:0] a,
                                                  input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    logic [DATA_W:0]        u;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    u = d[DATA_W] ? (DATA_W+1)'(-d) : (DATA_W+1)'(d);
    if (u > (DATA_W+1)'(SMAX)) return SMAX;
    return u[DATA_W-1:0];
  endfunction

endpackage

### hdl/nprf_mul.sv
// ----------------------------------------------------------------------------
// nprf_mul
// saturating fixed-point multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module nprf_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [nprf_pkg::DATA_W-1:0]   a_i,
  input  logic signed [nprf_pkg::DATA_W-1:0]   b_i,
  output logic                                 done_o,
  output logic signed [nprf_pkg::DATA_W-1:0]   res_o
);
  import nprf_pkg::*;

  logic                     run_q;
  logic                     done_q;
  logic [MUL_CNT_W-1:0]     step_q;
  logic [DATA_W-1:0]        ua_q, ub_q;
  logic                     neg_q;
  logic [2*DATA_W-1:0]      acc_q;
  logic signed [DATA_W-1:0] res_q;
  logic [HALF_W-1:0]        ha, hb;
  logic [DATA_W-1:0]        pp;
  logic [2*DATA_W-1:0]      pp_sh;

  // partial product select and alignment
  always_comb begin
    ha = step_q[1] ? ua_q[DATA_W-1:HALF_W] : ua_q[HALF_W-1:0];
    hb = step_q[0] ? ub_q[DATA_W-1:HALF_W] : ub_q[HALF_W-1:0];
    pp = ha * hb;
    case (step_q)
      MUL_CNT_W'(0): pp_sh = (2*DATA_W)'(pp);
      MUL_CNT_W'(1),
      MUL_CNT_W'(2): pp_sh = (2*DATA_W)'(pp) << HALF_W;
      MUL_CNT_W'(3): pp_sh = (2*DATA_W)'(pp) << DATA_W;
      default:       pp_sh = '0;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        if (step_q == MUL_CNT_W'(MUL_STEPS)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  // accumulate and saturate
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= mag(a_i);
      ub_q  <= mag(b_i);
      neg_q <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
      acc_q <= '0;
    end else if (run_q) begin
      if (step_q == MUL_CNT_W'(MUL_STEPS)) begin
        res_q <= from_mag(acc_q[FRAC_BITS+DATA_W-1:FRAC_BITS], neg_q,
                          |acc_q[2*DATA_W-1:FRAC_BITS+DATA_W]);
      end else begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/nprf_div.sv
// ----------------------------------------------------------------------------
// nprf_div
// saturating fixed-point divider, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nprf_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [nprf_pkg::DATA_W-1:0]   n_i,
  input  logic signed [nprf_pkg::DATA_W-1:0]   d_i,
  output logic                                 done_o,
  output logic signed [nprf_pkg::DATA_W-1:0]   res_o
);
  import nprf_pkg::*;

  logic                     run_q;
  logic                     done_q;
  logic [DIV_CNT_W-1:0]     cnt_q;
  logic [2*DATA_W-1:0]      dvd_q;
  logic [DATA_W-1:0]        rem_q, quo_q, ud_q;
  logic                     ovf_q, neg_q;
  logic signed [DATA_W-1:0] res_q;
  logic [DATA_W-1:0]        rem_sh, rem_nx;
  logic                     qbit;

  // one shift and subtract step
  always_comb begin
    rem_sh = {rem_q[DATA_W-2:0], dvd_q[2*DATA_W-1]};
    qbit   = rem_q[DATA_W-1] || (rem_sh >= ud_q);
    rem_nx = qbit ? rem_sh - ud_q : rem_sh;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= (2*DATA_W)'(mag(n_i)) << FRAC_BITS;
      ud_q  <= mag(d_i);
      neg_q <= n_i[DATA_W-1] ^ d_i[DATA_W-1];
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (run_q) begin
      if (cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
        res_q <= from_mag(quo_q, neg_q, ovf_q);
      end else begin
        dvd_q <= dvd_q << 1;
        rem_q <= rem_nx;
        quo_q <= {quo_q[DATA_W-2:0], qbit};
        if (qbit && (cnt_q < DIV_CNT_W'(DATA_W))) ovf_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/nprf_datapath.sv
// ----------------------------------------------------------------------------
// nprf_datapath
// coefficient and root storage, newton arithmetic, sorting and result registers
// ----------------------------------------------------------------------------
module nprf_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  nprf_pkg::dp_cmd_t                    cmd_i,
  output nprf_pkg::dp_status_t                 status_o,
  input  logic signed [nprf_pkg::DATA_W-1:0]   coeff_value_i,
  input  logic                                 last_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [nprf_pkg::DATA_W-1:0]          cfg_data_i,
  output logic                                 result_strobe_o,
  output logic signed [nprf_pkg::DATA_W-1:0]   root_value_o,
  output logic                                 root_found_o,
  output logic                                 diverged_o,
  output logic                                 last_root_o
);
  import nprf_pkg::*;

  // configuration
  logic [THR_W-1:0]         thr_q;
  logic signed [DATA_W-1:0] guess_q;

  // search state
  logic [CNT_W-1:0]         cnt_q;
  logic [DIX_W-1:0]         n_q, m_q, i_q, k_q, rfound_q, si_q, j_q, e_q;
  logic [RIX_W-1:0]         rp_q;
  logic [ITER_W-1:0]        iter_q;
  logic signed [DATA_W-1:0] x_q, xn_q, p_q, dp_q, q_q, v_q;
  logic [DATA_W-1:0]        diff_q, prev_q;
  logic                     ok_q;

  // stores
  logic signed [DATA_W-1:0] defl_q [MAX_DEGREE+1];
  logic signed [DATA_W-1:0] root_q [MAX_DEGREE];

  // results
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_found_q, out_div_q, out_last_q;

  logic [DIX_W-1:0]         rd_idx;
  logic signed [DATA_W-1:0] defl_rd, root_rd;
  logic                     mul_start, mul_done, div_done;
  logic signed [DATA_W-1:0] mul_a, mul_b, mres, qres;
  logic [DATA_W:0]          gdiff;
  dp_op_e                   op;

  assign op = cmd_i.op;

  // store reads
  always_comb begin
    case (op)
      OP_HSTART, OP_DSTART: rd_idx = m_q;
      default:              rd_idx = k_q - 1'b1;
    endcase
  end
  assign defl_rd = defl_q[rd_idx];
  assign root_rd = root_q[rp_q];

  // multiplier operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = p_q;
    mul_b     = x_q;
    case (op)
      OP_MUL_DP: begin
        mul_start = 1'b1;
        mul_a     = dp_q;
      end
      OP_MUL_P: begin
        mul_start = 1'b1;
      end
      OP_MUL_Q: begin
        mul_start = 1'b1;
        mul_a     = q_q;
      end
      default: ;
    endcase
  end

  nprf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  nprf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (op == OP_DIV_START),
    .n_i     (p_q),
    .d_i     (dp_q),
    .done_o  (div_done),
    .res_o   (qres)
  );

  // status toward the controller
  assign gdiff = {1'b0, diff_q} - {1'b0, prev_q};
  always_comb begin
    status_o.nonconst  = (cnt_q != '0);
    status_o.k_zero    = (k_q == '0);
    status_o.mul_done  = mul_done;
    status_o.div_done  = div_done;
    status_o.dp_zero   = (dp_q == '0);
    status_o.grow      = (iter_q > ITER_W'(1)) && !gdiff[DATA_W] &&
                         (gdiff[DATA_W-1:0] > ONE_Q);
    status_o.conv      = (diff_q <= {1'b0, thr_q});
    status_o.cap       = (iter_q >= ITER_W'(MAX_ITER));
    status_o.all_done  = (m_q == '0);
    status_o.sort_done = (si_q >= n_q);
    status_o.sort_move = (j_q != '0) && (root_rd > v_q);
    status_o.emit_last = (e_q == n_q - 1'b1);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      guess_q <= GUESS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CONV_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_INITIAL_GUESS:  guess_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      rfound_q    <= '0;
      x_q         <= '0;
      prev_q      <= '0;
    end else begin
      out_valid_q <= (op == OP_EMIT);
      case (op)
        OP_LOAD: begin
          if (last_i)                                cnt_q <= '0;
          else if (cnt_q <= CNT_W'(MAX_DEGREE))      cnt_q <= cnt_q + 1'b1;
        end
        OP_INIT: begin
          x_q      <= guess_q;
          rfound_q <= '0;
        end
        OP_ROOT_START: iter_q <= '0;
        OP_DIFF: begin
          x_q    <= xn_q;
          iter_q <= iter_q + 1'b1;
        end
        OP_CHK:    prev_q   <= diff_q;
        OP_DSTART: rfound_q <= i_q + 1'b1;
        default: ;
      endcase
    end
  end

  // working registers and stores
  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        if (cnt_q <= CNT_W'(MAX_DEGREE)) defl_q[cnt_q[DIX_W-1:0]] <= coeff_value_i;
        if (last_i) begin
          n_q <= (cnt_q == CNT_W'(MAX_DEGREE + 1)) ? DIX_W'(MAX_DEGREE)
                                                    : cnt_q[DIX_W-1:0];
        end
      end
      OP_INIT: begin
        i_q  <= '0;
        m_q  <= n_q;
        ok_q <= 1'b1;
      end
      OP_HSTART: begin
        p_q  <= defl_rd;
        dp_q <= '0;
        k_q  <= m_q;
      end
      OP_DP_ACC: dp_q <= sat_add(mres, p_q);
      OP_P_ACC: begin
        p_q <= sat_add(mres, defl_rd);
        k_q <= k_q - 1'b1;
      end
      OP_NEWTON: xn_q   <= sat_sub(x_q, qres);
      OP_DIFF:   diff_q <= step_size(xn_q, x_q);
      OP_DSTART: begin
        root_q[i_q[RIX_W-1:0]] <= x_q;
        q_q <= defl_rd;
        k_q <= m_q;
      end
      OP_DEFL: begin
        defl_q[rd_idx] <= q_q;
        q_q <= sat_add(defl_rd, mres);
        k_q <= k_q - 1'b1;
      end
      OP_NEXT_ROOT: begin
        i_q <= i_q + 1'b1;
        m_q <= m_q - 1'b1;
      end
      OP_SORT_INIT: begin
        si_q <= DIX_W'(1);
        rp_q <= RIX_W'(1);
      end
      OP_SORT_LOAD: begin
        v_q  <= root_rd;
        j_q  <= si_q;
        rp_q <= RIX_W'(si_q - 1'b1);
      end
      OP_SORT_SHIFT: begin
        root_q[j_q[RIX_W-1:0]] <= root_rd;
        j_q  <= j_q - 1'b1;
        rp_q <= rp_q - 1'b1;
      end
      OP_SORT_PLACE: begin
        root_q[j_q[RIX_W-1:0]] <= v_q;
        si_q <= si_q + 1'b1;
        rp_q <= RIX_W'(si_q + 1'b1);
      end
      OP_EMIT_INIT: begin
        e_q  <= '0;
        rp_q <= '0;
      end
      OP_EMIT: begin
        out_found_q <= (e_q < rfound_q);
        out_value_q <= (e_q < rfound_q) ? root_rd : '0;
        out_div_q   <= !ok_q;
        out_last_q  <= (e_q == n_q - 1'b1);
        e_q         <= e_q + 1'b1;
        rp_q        <= rp_q + 1'b1;
      end
      OP_ABORT: ok_q <= 1'b0;
      default: ;
    endcase
  end

  assign result_strobe_o = out_valid_q;
  assign root_value_o    = out_value_q;
  assign root_found_o    = out_found_q;
  assign diverged_o      = out_div_q;
  assign last_root_o     = out_last_q;

endmodule

### hdl/nprf_ctrl.sv
// ----------------------------------------------------------------------------
// nprf_ctrl
// sequencer for loading, newton search, deflation, sorting and result output
// ----------------------------------------------------------------------------
module nprf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   last_i,
  input  nprf_pkg::dp_status_t   status_i,
  output nprf_pkg::dp_cmd_t      cmd_o,
  output logic                   busy
);
  import nprf_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001,
    S_INIT   = 22'h000002,
    S_ROOT   = 22'h000004,
    S_HSTART = 22'h000008,
    S_HCHK   = 22'h000010,
    S_MDPW   = 22'h000020,
    S_MP     = 22'h000040,
    S_MPW    = 22'h000080,
    S_DIVCHK = 22'h000100,
    S_DIVW   = 22'h000200,
    S_DIFF   = 22'h000400,
    S_CHK    = 22'h000800,
    S_DSTART = 22'h001000,
    S_DCHK   = 22'h002000,
    S_DMW    = 22'h004000,
    S_RCHK   = 22'h008000,
    S_SINIT  = 22'h010000,
    S_SCHK   = 22'h020000,
    S_SCMP   = 22'h040000,
    S_ABORT  = 22'h080000,
    S_EINIT  = 22'h100000,
    S_EMIT   = 22'h200000
  } state_e;

  state_e state_q, state_d;
  dp_op_e op;

  // next state and command
  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op = OP_LOAD;
          if (last_i && status_i.nonconst) state_d = S_INIT;
        end
      end
      S_INIT: begin
        op      = OP_INIT;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        op      = OP_ROOT_START;
        state_d = S_HSTART;
      end
      S_HSTART: begin
        op      = OP_HSTART;
        state_d = S_HCHK;
      end
      // horner loop over the deflated coefficients
      S_HCHK: begin
        if (status_i.k_zero) begin
          state_d = S_DIVCHK;
        end else begin
          op      = OP_MUL_DP;
          state_d = S_MDPW;
        end
      end
      S_MDPW: begin
        if (status_i.mul_done) begin
          op      = OP_DP_ACC;
          state_d = S_MP;
        end
      end
      S_MP: begin
        op      = OP_MUL_P;
        state_d = S_MPW;
      end
      S_MPW: begin
        if (status_i.mul_done) begin
          op      = OP_P_ACC;
          state_d = S_HCHK;
        end
      end
      // newton step
      S_DIVCHK: begin
        if (status_i.dp_zero) begin
          state_d = S_ABORT;
        end else begin
          op      = OP_DIV_START;
          state_d = S_DIVW;
        end
      end
      S_DIVW: begin
        if (status_i.div_done) begin
          op      = OP_NEWTON;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        op      = OP_DIFF;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (status_i.grow) begin
          state_d = S_ABORT;
        end else begin
          op = OP_CHK;
          if (status_i.conv)     state_d = S_DSTART;
          else if (status_i.cap) state_d = S_ABORT;
          else                   state_d = S_HSTART;
        end
      end
      // deflation by synthetic division
      S_DSTART: begin
        op      = OP_DSTART;
        state_d = S_DCHK;
      end
      S_DCHK: begin
        if (status_i.k_zero) begin
          op      = OP_NEXT_ROOT;
          state_d = S_RCHK;
        end else begin
          op      = OP_MUL_Q;
          state_d = S_DMW;
        end
      end
      S_DMW: begin
        if (status_i.mul_done) begin
          op      = OP_DEFL;
          state_d = S_DCHK;
        end
      end
      S_RCHK: begin
        state_d = status_i.all_done ? S_SINIT : S_ROOT;
      end
      // insertion sort of the roots
      S_SINIT: begin
        op      = OP_SORT_INIT;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (status_i.sort_done) begin
          state_d = S_EINIT;
        end else begin
          op      = OP_SORT_LOAD;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (status_i.sort_move) begin
          op = OP_SORT_SHIFT;
        end else begin
          op      = OP_SORT_PLACE;
          state_d = S_SCHK;
        end
      end
      S_ABORT: begin
        op      = OP_ABORT;
        state_d = S_EINIT;
      end
      // one result per cycle
      S_EINIT: begin
        op      = OP_EMIT_INIT;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        op = OP_EMIT;
        if (status_i.emit_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.op = op;
  assign busy     = (state_q != S_IDLE);

endmodule

### hdl/newton_polynomial_root_finder_unit.sv
// ----------------------------------------------------------------------------
// newton_polynomial_root_finder_unit
// polynomial roots by newton iteration with deflation, signed q32.32 fixed point
// ----------------------------------------------------------------------------
//  channel   | handshake                      | payload
//  ----------+--------------------------------+---------------------------------
//  command   | start / busy (start & !busy)   | coeff_value_i, last_i
//  config    | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//  result    | result_strobe_o (one cycle)    | root_value_o, root_found_o,
//            |                                | diverged_o, last_root_o
//
//  a coefficient request is taken while busy is low; the last one starts the
//  search unless it completes a constant polynomial. each horner term costs two
//  multiplies (four 32x32 partial products on one shared multiplier), each
//  newton step adds a bit-serial divide; deflation costs one multiply per term;
//  results then leave one per cycle. no clearing pass after reset; the receiver
//  cannot stall, and config writes are always taken.
// ----------------------------------------------------------------------------
module newton_polynomial_root_finder_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [nprf_pkg::DATA_W-1:0]   coeff_value_i,
  input  logic                                 last_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_index_i,
  input  logic [nprf_pkg::DATA_W-1:0]          cfg_data_i,
  output logic                                 result_strobe_o,
  output logic signed [nprf_pkg::DATA_W-1:0]   root_value_o,
  output logic                                 root_found_o,
  output logic                                 diverged_o,
  output logic                                 last_root_o
);
  import nprf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  nprf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .last_i   (last_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // arithmetic and storage
  nprf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .coeff_value_i   (coeff_value_i),
    .last_i          (last_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .root_value_o    (root_value_o),
    .root_found_o    (root_found_o),
    .diverged_o      (diverged_o),
    .last_root_o     (last_root_o)
  );

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the newton root finder against a fixed-point predictor of its own:
// directed polynomials for the corner cases, then random polynomials built
// from known roots mixed with random coefficient noise, mostly under random gaps
// ----------------------------------------------------------------------------
module tb;
  import nprf_pkg::*;

  localparam int CYCLE_LIMIT = 40000000;

  typedef logic signed [DATA_W-1:0] q_t;

  typedef struct {
    q_t   value;
    logic found;
    logic aborted;
    logic final_slot;
  } root_res_t;

  // predictor and store of expected roots
  class root_scoreboard;
    logic [THR_W-1:0] thr;
    q_t               guess;
    q_t               coeffs[MAX_DEGREE+1];
    q_t               defl[MAX_DEGREE+1];
    q_t               roots[MAX_DEGREE];
    int               ncoeff;
    int               nfound;
    logic [DATA_W-1:0] prev_step;
    root_res_t        expected[$];
    int               errors;

    function new();
      thr       = THR_W'(4295);
      guess     = q_t'(64'd1 << FRAC_BITS);
      ncoeff    = 0;
      nfound    = 0;
      prev_step = '0;
      errors    = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [DATA_W-1:0] data);
      if (idx == CFG_CONV_THRESHOLD) thr = data[THR_W-1:0];
      else guess = q_t'(data);
    endfunction

    // saturate a magnitude with sign back to q_t
    function q_t clip(logic [DATA_W-1:0] m, logic neg, logic ovf);
      if (neg) return (ovf || m[DATA_W-1]) ? {1'b1, {(DATA_W-1){1'b0}}} : q_t'(-m);
      return (ovf || m[DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}} : q_t'(m);
    endfunction

    function logic [DATA_W-1:0] absval(q_t a);
      return a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    endfunction

    function q_t add_q(q_t a, q_t b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) return clip('0, s[DATA_W], 1'b1);
      return s[DATA_W-1:0];
    endfunction

    function q_t sub_q(q_t a, q_t b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) return clip('0, s[DATA_W], 1'b1);
      return s[DATA_W-1:0];
    endfunction

    // product cut to FRAC_BITS fraction bits, toward zero
    function q_t mul_q(q_t a, q_t b);
      logic [2*DATA_W-1:0] prod;
      prod = {{DATA_W{1'b0}}, absval(a)} * {{DATA_W{1'b0}}, absval(b)};
      return clip(prod[DATA_W+FRAC_BITS-1:FRAC_BITS], a[DATA_W-1] ^ b[DATA_W-1],
                  |prod[2*DATA_W-1:DATA_W+FRAC_BITS]);
    endfunction

    // (n << FRAC_BITS) / d, exact, toward zero
    function q_t div_q(q_t n, q_t d);
      logic [2*DATA_W-1:0] num, quo;
      num = {{DATA_W{1'b0}}, absval(n)} << FRAC_BITS;
      quo = num / {{DATA_W{1'b0}}, absval(d)};
      return clip(quo[DATA_W-1:0], n[DATA_W-1] ^ d[DATA_W-1], |quo[2*DATA_W-1:DATA_W]);
    endfunction

    function logic [DATA_W-1:0] dist_q(q_t a, q_t b);
      logic signed [DATA_W:0] d;
      logic [DATA_W:0]        u;
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      u = d[DATA_W] ? -d : d;
      if (u > {2'b00, {(DATA_W-1){1'b1}}}) return {1'b0, {(DATA_W-1){1'b1}}};
      return u[DATA_W-1:0];
    endfunction

    // newton search with deflation; 1 when every root converged
    function bit find_roots(int n);
      q_t x, p, dp, stp, xn, q, nxt;
      logic [DATA_W-1:0] diff;
      int m, iter;
      for (int k = 0; k <= MAX_DEGREE; k++) defl[k] = coeffs[k];
      nfound = 0;
      x = guess;
      for (int i = 0; i < n; i++) begin
        m = n - i;
        iter = 0;
        forever begin
          p  = defl[m];
          dp = '0;
          for (int k = m; k > 0; k--) begin
            dp = add_q(mul_q(dp, x), p);
            p  = add_q(mul_q(p, x), defl[k-1]);
          end
          if (dp == 0) return 0;
          stp  = div_q(p, dp);
          xn   = sub_q(x, stp);
          diff = dist_q(xn, x);
          x    = xn;
          iter++;
          if (iter > 1 && diff > prev_step && (diff - prev_step) > (64'd1 << FRAC_BITS))
            return 0;
          prev_step = diff;
          if (diff <= {1'b0, thr}) break;
          if (iter >= MAX_ITER) return 0;
        end
        roots[i] = x;
        nfound = i + 1;
        // synthetic division by (x - root)
        q = defl[m];
        for (int k = m; k > 0; k--) begin
          nxt       = add_q(defl[k-1], mul_q(x, q));
          defl[k-1] = q;
          q         = nxt;
        end
      end
      return 1;
    endfunction

    // accepted coefficient request
    function void note_coeff(q_t value, logic last);
      int n;
      bit ok;
      q_t v;
      root_res_t r;
      if (ncoeff < MAX_DEGREE + 1) begin
        coeffs[ncoeff] = value;
        ncoeff++;
      end
      if (!last) return;
      n = (ncoeff > 0) ? ncoeff - 1 : 0;
      ncoeff = 0;
      if (n == 0) return;
      ok = find_roots(n);
      if (ok) begin
        for (int i = 1; i < n; i++) begin
          int j;
          v = roots[i];
          j = i;
          while (j > 0 && roots[j-1] > v) begin
            roots[j] = roots[j-1];
            j--;
          end
          roots[j] = v;
        end
      end
      for (int i = 0; i < n; i++) begin
        r.found      = (i < nfound);
        r.value      = r.found ? roots[i] : '0;
        r.aborted    = !ok;
        r.final_slot = (i == n - 1);
        expected.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(root_res_t got);
      root_res_t exp_r;
      if (expected.size() == 0) begin
        report($sformatf("unexpected root %h", got.value));
        return;
      end
      exp_r = expected.pop_front();
      if (got.value !== exp_r.value)
        report($sformatf("root_value %h, want %h", got.value, exp_r.value));
      if (got.found !== exp_r.found)
        report($sformatf("root_found %b, want %b", got.found, exp_r.found));
      if (got.aborted !== exp_r.aborted)
        report($sformatf("diverged %b, want %b", got.aborted, exp_r.aborted));
      if (got.final_slot !== exp_r.final_slot)
        report($sformatf("last_root %b, want %b", got.final_slot, exp_r.final_slot));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  q_t                coeff_value_i = '0;
  logic              last_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = 1'b0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic              result_strobe_o;
  q_t                root_value_o;
  logic              root_found_o;
  logic              diverged_o;
  logic              last_root_o;

  root_scoreboard roots_sb = new();
  int             cycle_cnt = 0;
  bit             no_gaps = 0;

  newton_polynomial_root_finder_unit DUT (.*);

  always #1 clk_i = ~clk_i;

  // result capture
  always @(posedge clk_i) begin
    root_res_t got;
    if (rst_ni && result_strobe_o) begin
      got.value      = root_value_o;
      got.found      = root_found_o;
      got.aborted    = diverged_o;
      got.final_slot = last_root_o;
      roots_sb.check(got);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one coefficient request, held until taken
  task send_coeff(q_t value, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         = 1'b1;
    coeff_value_i = value;
    last_i        = last;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    roots_sb.note_coeff(value, last);
    @(negedge clk_i);
  endtask

  task send_poly(q_t cf[$]);
    foreach (cf[k]) send_coeff(cf[k], k == cf.size() - 1);
  endtask

  // wait until nothing is expected and the search has wound down
  task drain();
    @(negedge clk_i);
    start = 1'b0;
    while (roots_sb.pending() != 0 || busy) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task write_reg(cfg_idx_e idx, logic [DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    roots_sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic q_t rand_q();
    return {$urandom, $urandom};
  endfunction

  // polynomial lead * prod(d*x - r) with small roots r/d, d being 1 or 2
  task send_rooted(int deg);
    longint c[$], nc[$];
    q_t     cf[$];
    int     d, r;
    c.push_back($urandom_range(0, 1) ? -longint'($urandom_range(1, 3))
                                      : longint'($urandom_range(1, 3)));
    for (int f = 0; f < deg; f++) begin
      d = $urandom_range(1, 2);
      r = $urandom_range(0, 10) - 5;
      nc.delete();
      for (int k = 0; k <= c.size(); k++)
        nc.push_back((k > 0 ? d * c[k-1] : 0) - (k < c.size() ? r * c[k] : 0));
      c = nc;
    end
    foreach (c[k]) cf.push_back(q_t'(c[k]) <<< FRAC_BITS);
    send_poly(cf);
  endtask

  task send_random_item();
    int   kind, deg;
    q_t   cf[$];
    kind = $urandom_range(0, 19);
    if (kind < 15) begin
      send_rooted((kind < 13) ? $urandom_range(1, 4) : $urandom_range(5, 7));
    end else if (kind < 18) begin
      // coefficient noise over the full range
      deg = $urandom_range(1, 3);
      for (int k = 0; k <= deg; k++) cf.push_back(rand_q());
      send_poly(cf);
    end else begin
      // constant polynomial
      send_coeff(rand_q(), 1'b1);
    end
  endtask

  localparam logic [DATA_W-1:0] Q_ONE = 64'd1 << FRAC_BITS;

  initial begin
    q_t cf[$];
    logic [DATA_W-1:0] thr_set[5];
    logic [DATA_W-1:0] guess_set[5];
    int sent;

    thr_set   = '{64'd1, {1'b0, {63{1'b1}}}, 64'd1 << 20, 64'd4295, 64'd0};
    guess_set = '{{1'b1, {63{1'b0}}}, {1'b0, {63{1'b1}}}, -(Q_ONE * 5 / 2), 64'd0, 64'd0};

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: constant polynomial alone
    send_coeff(q_t'(5) <<< FRAC_BITS, 1'b1);
    // linear with extreme coefficients
    send_poly('{{1'b1, {63{1'b0}}}, {1'b0, {63{1'b1}}}});
    // linear 2x - 4
    send_poly('{-(q_t'(4) <<< FRAC_BITS), q_t'(2) <<< FRAC_BITS});
    // zero derivative at the start: x^2 - 2x + 2 from x = 1
    send_poly('{q_t'(2) <<< FRAC_BITS, -(q_t'(2) <<< FRAC_BITS), q_t'(Q_ONE)});
    // zero leading coefficient
    send_poly('{q_t'(Q_ONE), q_t'(Q_ONE), q_t'(0)});
    // too many coefficients: the dropped last one still starts the search
    for (int k = 0; k < MAX_DEGREE + 2; k++)
      cf.push_back(q_t'($urandom_range(0, 8)) <<< (FRAC_BITS - 2));
    send_poly(cf);
    drain();

    // random phases, each after the first under a new register setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_CONV_THRESHOLD,
                  (ph == 4) ? ({$urandom, $urandom} >> 1) : thr_set[ph-1]);
        write_reg(CFG_INITIAL_GUESS, (ph == 4) ? (rand_q() >>> 28) : guess_set[ph-1]);
      end
      no_gaps = (ph == 2);
      sent = 0;
      while (sent < 38) begin
        send_random_item();
        sent = sent + 4;
        if (ph == 1 && sent == 20) begin
          // hold off until the block has caught up
          start = 1'b0;
          while (roots_sb.pending() != 0) @(negedge clk_i);
        end
        if (ph == 3) no_gaps = $urandom_range(0, 3) == 0;
      end
      drain();
    end

    if (roots_sb.errors == 0 && roots_sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
